// File: rtl/pp_pkg.sv
// polygon perimeter package: item structs, widths, sequencer states
// and the request/response bundles of the shared square root unit
// no dependencies
package pp_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned RAD_W      = 2 * DIFF_W;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned ROOT_STEPS = ROOT_W;
  localparam int unsigned REM_W      = ROOT_W + 3;
  localparam int unsigned STEP_CNT_W = $clog2(ROOT_STEPS);
  localparam int unsigned SUM_W      = 21;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      last_vertex;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] perimeter;
    logic             saturated;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQX  = 6'b000010,
    ST_SQY  = 6'b000100,
    ST_GO   = 6'b001000,
    ST_WAIT = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

endpackage

// File: rtl/pp_sqrt.sv
// iterative floor square root, two radicand bits per cycle
// depends on pp_pkg
module pp_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pp_pkg::sqrt_req_t req_i,
  output pp_pkg::sqrt_rsp_t rsp_o
);

  logic [pp_pkg::RAD_W-1:0]      rad_q, rad_d;
  logic [pp_pkg::REM_W-1:0]      rem_q, rem_d;
  logic [pp_pkg::ROOT_W-1:0]     root_q, root_d;
  logic [pp_pkg::STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;

  logic [pp_pkg::REM_W-1:0] rem_sh;
  logic [pp_pkg::REM_W-1:0] trial;
  logic                     last_step;

  assign rem_sh    = {rem_q[pp_pkg::REM_W-3:0], rad_q[pp_pkg::RAD_W-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign last_step = (cnt_q == pp_pkg::STEP_CNT_W'(pp_pkg::ROOT_STEPS - 1));

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start && !busy_q) begin
      rad_d  = req_i.radicand;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[pp_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[pp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[pp_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("root done without a finished run");

  a_start_while_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("root started while busy");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.start && !busy_q) |=> busy_q && cnt_q == '0)
    else $error("root run did not begin");

endmodule

// File: rtl/polygon_perimeter.sv
// Polygon perimeter: one vertex item is taken, then each edge passes through
// the absolute difference (in the accepting cycle for an edge to a new vertex,
// in the last cycle of the previous edge for the closing edge), the shared
// multiplier (dx squared, then plus dy squared), a start of the two-bit-per-step
// square root unit, its run, and the addition of the root into the saturating
// sum. An ordinary vertex keeps input stall high from when it is taken until
// its edge has been added. A closing vertex keeps it high through both of its
// edges and the emit state, which loads the result register, and longer while
// an earlier result still waits there under output stall. The first vertex of
// a polygon goes straight back to idle, or through the emit state when it is
// also the last. Input stall is low only while the sequencer is idle; a
// finished result waits in the output register while the next vertex is taken.
// depends on pp_pkg and pp_sqrt
module polygon_perimeter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pp_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pp_pkg::out_item_t out_item_o
);

  pp_pkg::state_e state_q, state_d;

  logic signed [pp_pkg::COORD_W-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic signed [pp_pkg::COORD_W-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [pp_pkg::SUM_W-1:0]          sum_q, sum_d;
  logic                              have_q, have_d;
  logic                              clamp_q, clamp_d;
  logic                              last_q, last_d;
  logic                              closing_q, closing_d;
  logic [pp_pkg::DIFF_W-1:0]         dx_q, dx_d, dy_q, dy_d;
  logic [pp_pkg::RAD_W-1:0]          rad_q, rad_d;
  logic                              out_valid_q, out_valid_d;
  pp_pkg::out_item_t                 out_q, out_d;

  logic                              in_acc;
  logic signed [pp_pkg::COORD_W-1:0] opa_x, opa_y, opb_x, opb_y;
  logic signed [pp_pkg::DIFF_W-1:0]  diff_x, diff_y;
  logic [pp_pkg::DIFF_W-1:0]         mul_a;
  logic [pp_pkg::RAD_W-1:0]          mul_p;
  logic [pp_pkg::SUM_W:0]            sum_ext;
  pp_pkg::sqrt_req_t                 sq_req;
  pp_pkg::sqrt_rsp_t                 sq_rsp;

  assign in_stall_o = (state_q != pp_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // shared absolute difference: new edge from the incoming vertex, closing edge to the first
  always_comb begin
    if (state_q == pp_pkg::ST_IDLE) begin
      opb_x = in_item_i.x_coord;
      opb_y = in_item_i.y_coord;
    end else begin
      opb_x = first_x_q;
      opb_y = first_y_q;
    end
    opa_x  = prev_x_q;
    opa_y  = prev_y_q;
    diff_x = {opa_x[pp_pkg::COORD_W-1], opa_x} - {opb_x[pp_pkg::COORD_W-1], opb_x};
    diff_y = {opa_y[pp_pkg::COORD_W-1], opa_y} - {opb_y[pp_pkg::COORD_W-1], opb_y};
  end

  // shared multiplier
  assign mul_a = (state_q == pp_pkg::ST_SQX) ? dx_q : dy_q;
  assign mul_p = mul_a * mul_a;

  assign sum_ext = {1'b0, sum_q} + {{(pp_pkg::SUM_W + 1 - pp_pkg::ROOT_W){1'b0}}, sq_rsp.root};

  assign sq_req.start    = (state_q == pp_pkg::ST_GO);
  assign sq_req.radicand = rad_q;

  pp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  always_comb begin
    state_d     = state_q;
    first_x_d   = first_x_q;
    first_y_d   = first_y_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    sum_d       = sum_q;
    have_d      = have_q;
    clamp_d     = clamp_q;
    last_d      = last_q;
    closing_d   = closing_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    rad_d       = rad_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      pp_pkg::ST_IDLE: begin
        if (in_acc) begin
          prev_x_d  = in_item_i.x_coord;
          prev_y_d  = in_item_i.y_coord;
          last_d    = in_item_i.last_vertex;
          closing_d = 1'b0;
          dx_d      = diff_x[pp_pkg::DIFF_W-1] ? -diff_x : diff_x;
          dy_d      = diff_y[pp_pkg::DIFF_W-1] ? -diff_y : diff_y;
          if (!have_q) begin
            first_x_d = in_item_i.x_coord;
            first_y_d = in_item_i.y_coord;
            sum_d     = '0;
            clamp_d   = 1'b0;
            have_d    = 1'b1;
            state_d   = in_item_i.last_vertex ? pp_pkg::ST_EMIT : pp_pkg::ST_IDLE;
          end else begin
            state_d = pp_pkg::ST_SQX;
          end
        end
      end
      pp_pkg::ST_SQX: begin
        rad_d   = mul_p;
        state_d = pp_pkg::ST_SQY;
      end
      pp_pkg::ST_SQY: begin
        rad_d   = rad_q + mul_p;
        state_d = pp_pkg::ST_GO;
      end
      pp_pkg::ST_GO: begin
        state_d = pp_pkg::ST_WAIT;
      end
      pp_pkg::ST_WAIT: begin
        if (sq_rsp.done) begin
          if (sum_ext > {1'b0, pp_pkg::SUM_MAX}) begin
            sum_d   = pp_pkg::SUM_MAX;
            clamp_d = 1'b1;
          end else begin
            sum_d = sum_ext[pp_pkg::SUM_W-1:0];
          end
          if (last_q && !closing_q) begin
            closing_d = 1'b1;
            dx_d      = diff_x[pp_pkg::DIFF_W-1] ? -diff_x : diff_x;
            dy_d      = diff_y[pp_pkg::DIFF_W-1] ? -diff_y : diff_y;
            state_d   = pp_pkg::ST_SQX;
          end else if (last_q) begin
            state_d = pp_pkg::ST_EMIT;
          end else begin
            state_d = pp_pkg::ST_IDLE;
          end
        end
      end
      pp_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.perimeter = sum_q;
          out_d.saturated = clamp_q;
          out_valid_d     = 1'b1;
          have_d          = 1'b0;
          sum_d           = '0;
          clamp_d         = 1'b0;
          closing_d       = 1'b0;
          state_d         = pp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pp_pkg::ST_IDLE;
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      sum_q       <= '0;
      have_q      <= 1'b0;
      clamp_q     <= 1'b0;
      last_q      <= 1'b0;
      closing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_x_q   <= first_x_d;
      first_y_q   <= first_y_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      sum_q       <= sum_d;
      have_q      <= have_d;
      clamp_q     <= clamp_d;
      last_q      <= last_d;
      closing_q   <= closing_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    rad_q <= rad_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_root_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_rsp.done |-> state_q == pp_pkg::ST_WAIT)
    else $error("square root finished outside its wait state");

  a_clamp_holds_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clamp_q |-> sum_q == pp_pkg::SUM_MAX)
    else $error("clamped sum below maximum");

  a_sat_item_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.saturated) |-> out_q.perimeter == pp_pkg::SUM_MAX)
    else $error("saturated item below maximum");

  a_vertex_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> have_q)
    else $error("accepted vertex not kept");

endmodule
